FILE: design/can_bit_timing_search_defines.svh
// Assertion macros for the checker file of the bit timing search.
// No dependencies; the including module must provide clk and rst_n.
`ifndef CAN_BIT_TIMING_SEARCH_DEFINES_SVH
`define CAN_BIT_TIMING_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define CBTS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bit timing search check failed");

// Next-cycle implication, disabled while reset is active.
`define CBTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bit timing search check failed");

`endif

FILE: design/cbts_pkg.sv
// Shared types and constants of the CAN bit timing search.
// Used by the controller, the datapath, the divider, the top level and the checker.
package cbts_pkg;

    // Width of the shared divider operands.
    localparam int DIV_W = 30;
    localparam int CNT_W = 5;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_PARAM = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_CLOCK  = 3'd0;
    localparam logic [2:0] REG_PMIN   = 3'd1;
    localparam logic [2:0] REG_PMAX   = 3'd2;
    localparam logic [2:0] REG_PSTEP  = 3'd3;
    localparam logic [2:0] REG_S1MIN  = 3'd4;
    localparam logic [2:0] REG_S1MAX  = 3'd5;
    localparam logic [2:0] REG_S2MIN  = 3'd6;
    localparam logic [2:0] REG_S2MAX  = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE, S_SPAN, S_SPAN_WAIT, S_CHECK, S_DIV_CLK, S_CLK_WAIT, S_RATE_WAIT,
        S_TQ, S_EVAL, S_SP_WAIT, S_SCORE, S_NEXT, S_FINAL, S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_DIV_SPAN, OP_CHECK, OP_DIV_CLK, OP_DIV_RATE, OP_MUL,
        OP_EVAL, OP_SCORE, OP_NEXT_P, OP_FINAL, OP_OUTPUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic check_ok;
        logic stop;
        logic too_many;
        logic skip;
        logic better;
        logic exact;
        logic last_p;
    } stat_t;

endpackage

FILE: design/cbts_divider.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on cbts_pkg for the operand width.
module cbts_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cbts_pkg::DIV_W-1:0] dividend,
    input  logic [cbts_pkg::DIV_W-1:0] divisor,
    output logic                      busy,
    output logic [cbts_pkg::DIV_W-1:0] quot,
    output logic [cbts_pkg::DIV_W-1:0] rem
);
    import cbts_pkg::*;

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    // One shift and trial subtraction per cycle.
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    // Control: busy flag and step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

FILE: design/cbts_datapath.sv
// Datapath of the bit timing search: request and best-candidate registers,
// limit checks, segment arithmetic and the shared divider. Uses cbts_pkg.
module cbts_datapath #(
    parameter int JUMP_MAX = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cbts_pkg::cmd_t       cmd,
    output cbts_pkg::stat_t      stat,
    input  logic [29:0]          clk_freq,
    input  logic [10:0]          prescaler_min,
    input  logic [10:0]          prescaler_max,
    input  logic [10:0]          prescaler_step,
    input  logic [8:0]           seg1_min,
    input  logic [8:0]           seg1_max,
    input  logic [7:0]           seg2_min,
    input  logic [7:0]           seg2_max,
    input  logic [23:0]          bit_rate,
    input  logic [10:0]          target_point,
    input  logic                 jump_from_seg2,
    input  logic [7:0]           jump_width,
    input  logic [8:0]           min_quanta,
    output logic [1:0]           status,
    output logic [10:0]          best_prescaler,
    output logic [8:0]           best_seg1,
    output logic [7:0]           best_seg2,
    output logic [7:0]           best_jump
);
    import cbts_pkg::*;

    localparam logic [7:0] JUMP_CAP = 8'(JUMP_MAX);
    localparam logic       JUMP_BAD = (JUMP_MAX < 1);

    // Request registers.
    logic [23:0] rate_reg;
    logic [10:0] point_reg;
    logic        from2_reg;
    logic [7:0]  jw_reg;
    logic [8:0]  minq_reg;

    // Search registers.
    logic [10:0] p_reg;
    logic [9:0]  tq_reg;
    logic [19:0] prod_reg;
    logic [8:0]  s1_reg;
    logic [7:0]  s2_reg;
    logic        found_reg;
    logic [10:0] best_score_reg;
    logic [10:0] bp_reg;
    logic [8:0]  b1_reg;
    logic [7:0]  b2_reg;
    logic [7:0]  bj_reg;
    logic [1:0]  res_reg;

    // Output registers.
    logic [1:0]  status_reg;
    logic [10:0] out_p_reg;
    logic [8:0]  out_s1_reg;
    logic [7:0]  out_s2_reg;
    logic [7:0]  out_j_reg;

    logic             div_start;
    logic [DIV_W-1:0] div_a;
    logic [DIV_W-1:0] div_b;
    logic             div_busy;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;

    logic [1:0]  check_code;
    logic [9:0]  lim_lo;
    logic [9:0]  lim_hi;
    logic [20:0] s2_round;
    logic [10:0] s2_raw;
    logic [7:0]  s2_c;
    logic        skip_top;
    logic        skip_one;
    logic [9:0]  s1_c;
    logic        skip_s1;
    logic [10:0] sp;
    logic [10:0] score;
    logic [7:0]  jump_c;

    cbts_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quot     (quot),
        .rem      (rem)
    );

    // Divider operand selection.
    always_comb
    begin
        div_start = 1'b1;
        div_a     = '0;
        div_b     = '0;
        unique case (cmd.op)
            OP_DIV_SPAN:
            begin
                div_a = DIV_W'(prescaler_max - prescaler_min);
                div_b = DIV_W'(prescaler_step);
            end
            OP_DIV_CLK:
            begin
                div_a = clk_freq;
                div_b = DIV_W'(p_reg);
            end
            OP_DIV_RATE:
            begin
                div_a = quot;
                div_b = DIV_W'(rate_reg);
            end
            OP_EVAL:
            begin
                div_a = DIV_W'({s1_c + 10'd1, 10'd0});
                div_b = DIV_W'(tq_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Limit and request checks, first failure wins.
    always_comb
    begin
        priority if (prescaler_max < prescaler_min)                 check_code = ST_RANGE;
        else if (prescaler_step == '0)                              check_code = ST_PARAM;
        else if (prescaler_min == '0)                               check_code = ST_PARAM;
        else if (rem != '0)                                         check_code = ST_PARAM;
        else if (seg1_max < seg1_min)                               check_code = ST_RANGE;
        else if (seg2_max < seg2_min)                               check_code = ST_RANGE;
        else if (JUMP_BAD)                                          check_code = ST_RANGE;
        else if (clk_freq == '0)                                    check_code = ST_RANGE;
        else if (point_reg == '0 || point_reg >= 11'd1024)          check_code = ST_RANGE;
        else if (!from2_reg && jw_reg == '0)                        check_code = ST_PARAM;
        else if (!from2_reg && 32'(jw_reg) > 32'(JUMP_MAX))         check_code = ST_RANGE;
        else if (rate_reg == '0)                                    check_code = ST_RANGE;
        else                                                        check_code = ST_OK;
    end

    // Quanta bounds from the segment limits.
    assign lim_lo = 10'd1 + 10'(seg1_min) + 10'(seg2_min);
    assign lim_hi = 10'd1 + 10'(seg1_max) + 10'(seg2_max);

    // Phase segment two rounding and clamping, then segment one.
    assign s2_round = 21'(prod_reg) + 21'd512;
    assign s2_raw   = s2_round[20:10];
    always_comb
    begin
        skip_top = 1'b0;
        priority if (s2_raw < 11'(seg2_min))
        begin
            s2_c = seg2_min;
        end
        else if (s2_raw > 11'(seg2_max))
        begin
            s2_c     = seg2_max;
            skip_top = (10'(seg2_max) + 10'd3) > tq_reg;
        end
        else
        begin
            s2_c = s2_raw[7:0];
        end
    end
    assign skip_one = (10'(s2_c) + 10'd1) > tq_reg;
    assign s1_c     = tq_reg - 10'd1 - 10'(s2_c);
    assign skip_s1  = (s1_c < 10'(seg1_min)) || (s1_c > 10'(seg1_max));

    // Sample point distance from the target.
    assign sp     = quot[10:0];
    assign score  = (sp <= point_reg) ? (point_reg - sp) : (sp - point_reg);
    assign jump_c = from2_reg ? ((s2_reg > JUMP_CAP) ? JUMP_CAP : s2_reg) : jw_reg;

    // Status toward the controller.
    always_comb
    begin
        stat.div_busy = div_busy;
        stat.check_ok = (check_code == ST_OK);
        stat.stop     = ((minq_reg != '0) && (quot < DIV_W'(minq_reg))) ||
                        (quot < DIV_W'(lim_lo));
        stat.too_many = quot > DIV_W'(lim_hi);
        stat.skip     = skip_top || skip_one || skip_s1;
        stat.better   = !found_reg || (score < best_score_reg);
        stat.exact    = (score == '0);
        stat.last_p   = (p_reg == prescaler_max);
    end

    // Register updates by command.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                rate_reg  <= bit_rate;
                point_reg <= target_point;
                from2_reg <= jump_from_seg2;
                jw_reg    <= jump_width;
                minq_reg  <= min_quanta;
                p_reg     <= prescaler_min;
                found_reg <= 1'b0;
            end
            OP_CHECK:
            begin
                res_reg <= check_code;
            end
            OP_MUL:
            begin
                tq_reg   <= quot[9:0];
                prod_reg <= 20'(10'd1023 - point_reg[9:0] + 10'd1) * 20'(quot[9:0]);
            end
            OP_EVAL:
            begin
                s1_reg <= s1_c[8:0];
                s2_reg <= s2_c;
            end
            OP_SCORE:
            begin
                if (!found_reg || (score < best_score_reg))
                begin
                    found_reg      <= 1'b1;
                    best_score_reg <= score;
                    bp_reg         <= p_reg;
                    b1_reg         <= s1_reg;
                    b2_reg         <= s2_reg;
                    bj_reg         <= jump_c;
                end
            end
            OP_NEXT_P:
            begin
                p_reg <= p_reg + prescaler_step;
            end
            OP_FINAL:
            begin
                if (!found_reg)
                begin
                    res_reg <= ST_NONE;
                end
            end
            OP_OUTPUT:
            begin
                status_reg <= res_reg;
                out_p_reg  <= (res_reg == ST_OK) ? bp_reg : '0;
                out_s1_reg <= (res_reg == ST_OK) ? b1_reg : '0;
                out_s2_reg <= (res_reg == ST_OK) ? b2_reg : '0;
                out_j_reg  <= (res_reg == ST_OK) ? bj_reg : '0;
            end
            default:
            begin
            end
        endcase
    end

    assign status         = status_reg;
    assign best_prescaler = out_p_reg;
    assign best_seg1      = out_s1_reg;
    assign best_seg2      = out_s2_reg;
    assign best_jump      = out_j_reg;

endmodule

FILE: design/cbts_ctrl.sv
// Controller of the bit timing search: sequences checks, divisions and the
// prescaler loop, and owns both handshakes. Uses cbts_pkg.
module cbts_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output cbts_pkg::cmd_t  cmd,
    input  cbts_pkg::stat_t stat
);
    import cbts_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (in_valid) state_next = S_SPAN;
            S_SPAN:      state_next = S_SPAN_WAIT;
            S_SPAN_WAIT: if (!stat.div_busy) state_next = S_CHECK;
            S_CHECK:     state_next = stat.check_ok ? S_DIV_CLK : S_DONE;
            S_DIV_CLK:   state_next = S_CLK_WAIT;
            S_CLK_WAIT:  if (!stat.div_busy) state_next = S_RATE_WAIT;
            S_RATE_WAIT: if (!stat.div_busy) state_next = S_TQ;
            S_TQ:
            begin
                priority if (stat.stop)  state_next = S_FINAL;
                else if (stat.too_many)  state_next = S_NEXT;
                else                     state_next = S_EVAL;
            end
            S_EVAL:      state_next = stat.skip ? S_NEXT : S_SP_WAIT;
            S_SP_WAIT:   if (!stat.div_busy) state_next = S_SCORE;
            S_SCORE:     state_next = (stat.better && stat.exact) ? S_FINAL : S_NEXT;
            S_NEXT:      state_next = stat.last_p ? S_FINAL : S_DIV_CLK;
            S_FINAL:     state_next = S_DONE;
            S_DONE:      if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Commands toward the datapath.
    always_comb
    begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_IDLE:      if (in_valid) cmd.op = OP_LOAD;
            S_SPAN:      cmd.op = OP_DIV_SPAN;
            S_CHECK:     cmd.op = OP_CHECK;
            S_DIV_CLK:   cmd.op = OP_DIV_CLK;
            S_CLK_WAIT:  if (!stat.div_busy) cmd.op = OP_DIV_RATE;
            S_TQ:        if (!stat.stop && !stat.too_many) cmd.op = OP_MUL;
            S_EVAL:      if (!stat.skip) cmd.op = OP_EVAL;
            S_SCORE:     cmd.op = OP_SCORE;
            S_NEXT:      if (!stat.last_p) cmd.op = OP_NEXT_P;
            S_FINAL:     cmd.op = OP_FINAL;
            S_DONE:      if (out_free) cmd.op = OP_OUTPUT;
            default:     cmd.op = OP_NONE;
        endcase
    end

    // Output valid: set when a result is loaded, cleared when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (state_reg == S_DONE && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: design/can_bit_timing_search.sv
// Top level of the CAN bit timing search: configuration registers on an APB
// port, controller and datapath. Uses cbts_pkg, cbts_ctrl and cbts_datapath.
//
//   channel  direction  handshake            payload
//   in       into       in_valid/in_stall    bit_rate target_point jump_from_seg2
//                                            jump_width min_quanta
//   out      out of     out_valid/out_stall  status best_prescaler best_seg1
//                                            best_seg2 best_jump
//   config   into       psel/penable/pready  paddr pwdata prdata
//
// A transaction runs one division of the shared divider for its checks and
// handover, then up to three divisions per prescaler tried.
// Reset loads the documented register defaults; no clearing pass is needed.
// A new transaction is taken while the previous result waits in its output
// register; a stalled result blocks only the handover of the next one.
module can_bit_timing_search #(
    parameter int JUMP_MAX = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [23:0] bit_rate,
    input  logic [10:0] target_point,
    input  logic        jump_from_seg2,
    input  logic [7:0]  jump_width,
    input  logic [8:0]  min_quanta,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [10:0] best_prescaler,
    output logic [8:0]  best_seg1,
    output logic [7:0]  best_seg2,
    output logic [7:0]  best_jump
);
    import cbts_pkg::*;

    logic [29:0] clk_freq_reg;
    logic [10:0] pmin_reg;
    logic [10:0] pmax_reg;
    logic [10:0] pstep_reg;
    logic [8:0]  s1min_reg;
    logic [8:0]  s1max_reg;
    logic [7:0]  s2min_reg;
    logic [7:0]  s2max_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;
    cmd_t        cmd;
    stat_t       stat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_freq_reg <= 30'd80000000;
            pmin_reg     <= 11'd1;
            pmax_reg     <= 11'd1024;
            pstep_reg    <= 11'd1;
            s1min_reg    <= 9'd2;
            s1max_reg    <= 9'd256;
            s2min_reg    <= 8'd2;
            s2max_reg    <= 8'd128;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CLOCK: clk_freq_reg <= pwdata[29:0];
                REG_PMIN:  pmin_reg     <= pwdata[10:0];
                REG_PMAX:  pmax_reg     <= pwdata[10:0];
                REG_PSTEP: pstep_reg    <= pwdata[10:0];
                REG_S1MIN: s1min_reg    <= pwdata[8:0];
                REG_S1MAX: s1max_reg    <= pwdata[8:0];
                REG_S2MIN: s2min_reg    <= pwdata[7:0];
                REG_S2MAX: s2max_reg    <= pwdata[7:0];
                default:   clk_freq_reg <= clk_freq_reg;
            endcase
        end
    end

    // Configuration register reads.
    always_comb
    begin
        unique case (reg_idx)
            REG_CLOCK: prdata = 32'(clk_freq_reg);
            REG_PMIN:  prdata = 32'(pmin_reg);
            REG_PMAX:  prdata = 32'(pmax_reg);
            REG_PSTEP: prdata = 32'(pstep_reg);
            REG_S1MIN: prdata = 32'(s1min_reg);
            REG_S1MAX: prdata = 32'(s1max_reg);
            REG_S2MIN: prdata = 32'(s2min_reg);
            REG_S2MAX: prdata = 32'(s2max_reg);
            default:   prdata = '0;
        endcase
    end

    cbts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    cbts_datapath #(
        .JUMP_MAX (JUMP_MAX)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .clk_freq       (clk_freq_reg),
        .prescaler_min  (pmin_reg),
        .prescaler_max  (pmax_reg),
        .prescaler_step (pstep_reg),
        .seg1_min       (s1min_reg),
        .seg1_max       (s1max_reg),
        .seg2_min       (s2min_reg),
        .seg2_max       (s2max_reg),
        .bit_rate       (bit_rate),
        .target_point   (target_point),
        .jump_from_seg2 (jump_from_seg2),
        .jump_width     (jump_width),
        .min_quanta     (min_quanta),
        .status         (status),
        .best_prescaler (best_prescaler),
        .best_seg1      (best_seg1),
        .best_seg2      (best_seg2),
        .best_jump      (best_jump)
    );

endmodule

FILE: design/cbts_checker.sv
// Port-level checks of the bit timing search and their bind to the top level.
// Uses cbts_pkg and can_bit_timing_search_defines.svh.
`include "can_bit_timing_search_defines.svh"

module cbts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [10:0] best_prescaler,
    input logic [8:0]  best_seg1,
    input logic [7:0]  best_seg2,
    input logic [7:0]  best_jump
);
    import cbts_pkg::*;

    // A failed request carries an all-zero timing.
    `CBTS_ASSERT_IMPL(a_err_zero, out_valid && status != ST_OK, best_prescaler == '0 && best_seg1 == '0 && best_seg2 == '0 && best_jump == '0)

    // A successful result always names a real prescaler.
    `CBTS_ASSERT_IMPL(a_ok_presc, out_valid && status == ST_OK, best_prescaler != '0)

    // After a transaction is taken the block is busy with it.
    `CBTS_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall)

    // A stalled result holds.
    `CBTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(best_prescaler))

endmodule

bind can_bit_timing_search cbts_checker u_cbts_checker (.*);

FILE: tb/tb_can_bit_timing_search.sv
// Self-checking testbench of the CAN bit timing search: directed and random requests
// checked against a predictor of the prescaler search. Depends on cbts_pkg and the
// can_bit_timing_search RTL.
module tb_can_bit_timing_search;
    timeunit 1ns;
    timeprecision 1ps;
    import cbts_pkg::*;

    localparam int JUMP_LIMIT = 128;
    localparam int unsigned SCALE = 1024;

    typedef struct {
        logic [23:0] rate;
        logic [10:0] point;
        logic        from2;
        logic [7:0]  jw;
        logic [8:0]  minq;
    } request_t;

    typedef struct {
        logic [1:0]  st;
        logic [10:0] presc;
        logic [8:0]  s1;
        logic [7:0]  s2;
        logic [7:0]  sjw;
    } timing_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [23:0] bit_rate;
    logic [10:0] target_point;
    logic        jump_from_seg2;
    logic [7:0]  jump_width;
    logic [8:0]  min_quanta;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [10:0] best_prescaler;
    logic [8:0]  best_seg1;
    logic [7:0]  best_seg2;
    logic [7:0]  best_jump;

    // Shadow copy of the timing limits, indexed by register.
    int unsigned limits [8];
    timing_t     pending_timings [$];
    int          error_count = 0;
    bit          quiet = 0;
    int          hold_left = 0;

    can_bit_timing_search #(.JUMP_MAX(JUMP_LIMIT)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .bit_rate(bit_rate), .target_point(target_point),
        .jump_from_seg2(jump_from_seg2), .jump_width(jump_width),
        .min_quanta(min_quanta),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .best_prescaler(best_prescaler), .best_seg1(best_seg1),
        .best_seg2(best_seg2), .best_jump(best_jump)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Generous fixed limit on the whole run.
    initial
    begin
        #400ms;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Check the request and limits, then search the prescalers for the timing closest to the requested sample point.
    function automatic timing_t predict_timing(request_t rq);
        timing_t     res;
        logic [1:0]  st;
        int unsigned p, tq, s1, s2, sp, score, best;
        bit          found;
        res = '{default: '0};
        best = SCALE;
        found = 0;
        st = ST_OK;
        if (limits[REG_PMAX] < limits[REG_PMIN]) st = ST_RANGE;
        else if (limits[REG_PSTEP] == 0) st = ST_PARAM;
        else if (limits[REG_PMIN] == 0) st = ST_PARAM;
        else if (((limits[REG_PMAX] - limits[REG_PMIN]) % limits[REG_PSTEP]) != 0)
            st = ST_PARAM;
        else if (limits[REG_S1MAX] < limits[REG_S1MIN]) st = ST_RANGE;
        else if (limits[REG_S2MAX] < limits[REG_S2MIN]) st = ST_RANGE;
        else if (limits[REG_CLOCK] == 0) st = ST_RANGE;
        else if (rq.point == 0 || rq.point >= SCALE) st = ST_RANGE;
        else if (!rq.from2 && rq.jw == 0) st = ST_PARAM;
        else if (!rq.from2 && rq.jw > JUMP_LIMIT) st = ST_RANGE;
        else if (rq.rate == 0) st = ST_RANGE;

        if (st == ST_OK)
        begin
            for (p = limits[REG_PMIN]; p <= limits[REG_PMAX]; p += limits[REG_PSTEP])
            begin
                tq = (limits[REG_CLOCK] / p) / rq.rate;
                if (rq.minq != 0 && tq < rq.minq) break;
                if (tq < 1 + limits[REG_S1MIN] + limits[REG_S2MIN]) break;
                if (tq > 1 + limits[REG_S1MAX] + limits[REG_S2MAX]) continue;
                s2 = int'((longint'(SCALE - rq.point) * tq + SCALE / 2) / SCALE);
                if (s2 < limits[REG_S2MIN])
                    s2 = limits[REG_S2MIN];
                else if (s2 > limits[REG_S2MAX])
                begin
                    s2 = limits[REG_S2MAX];
                    if (s2 + 3 > tq) continue;
                end
                if (s2 + 1 > tq) continue;
                s1 = tq - 1 - s2;
                if (s1 < limits[REG_S1MIN] || s1 > limits[REG_S1MAX]) continue;
                sp = int'((longint'(1 + s1) * SCALE) / tq);
                score = (sp <= rq.point) ? rq.point - sp : sp - rq.point;
                if (!found || score < best)
                begin
                    found = 1;
                    best = score;
                    res.presc = 11'(p);
                    res.s1 = 9'(s1);
                    res.s2 = 8'(s2);
                    res.sjw = rq.from2 ? ((s2 > JUMP_LIMIT) ? 8'(JUMP_LIMIT) : 8'(s2))
                                       : rq.jw;
                    if (score == 0) break;
                end
            end
            if (!found) st = ST_NONE;
        end
        if (st != ST_OK) res = '{default: '0};
        res.st = st;
        return res;
    endfunction

    // Compare each accepted result with the oldest pending timing.
    always @(posedge clk)
    begin
        timing_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_timings.size() == 0)
                report_mismatch("unexpected result, status", status, 0);
            else
            begin
                want = pending_timings.pop_front();
                if (status !== want.st) report_mismatch("status", status, want.st);
                if (best_prescaler !== want.presc)
                    report_mismatch("prescaler", best_prescaler, want.presc);
                if (best_seg1 !== want.s1) report_mismatch("seg1", best_seg1, want.s1);
                if (best_seg2 !== want.s2) report_mismatch("seg2", best_seg2, want.s2);
                if (best_jump !== want.sjw) report_mismatch("sjw", best_jump, want.sjw);
            end
        end
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !quiet && ($urandom_range(0, 99) < 7);
        end
    end

    // Offer one request; returns at the falling edge after the transaction.
    task automatic send_request(input request_t rq);
        while (!quiet && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        bit_rate <= rq.rate;
        target_point <= rq.point;
        jump_from_seg2 <= rq.from2;
        jump_width <= rq.jw;
        min_quanta <= rq.minq;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_timings.push_back(predict_timing(rq));
        @(negedge clk);
    endtask

    task automatic send_fields(input int rate, input int point, input bit from2,
                               input int jw, input int minq);
        request_t rq;
        rq.rate = 24'(rate);
        rq.point = 11'(point);
        rq.from2 = from2;
        rq.jw = 8'(jw);
        rq.minq = 9'(minq);
        send_request(rq);
    endtask

    // Stop offering and wait until every pending result has arrived.
    task automatic drain;
        in_valid <= 1'b0;
        wait (pending_timings.size() == 0);
        repeat (20) @(negedge clk);
    endtask

    // Write a limit register over APB, then read it back.
    task automatic write_limit(input logic [2:0] idx, input int unsigned value);
        int unsigned mask;
        case (idx)
            REG_CLOCK: mask = 32'h3FFF_FFFF;
            REG_PMIN, REG_PMAX, REG_PSTEP: mask = 32'h7FF;
            REG_S1MIN, REG_S1MAX: mask = 32'h1FF;
            default: mask = 32'hFF;
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        limits[idx] = value & mask;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== limits[idx]) report_mismatch("register readback", prdata, limits[idx]);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_all(input int unsigned clock, input int pmin, input int pmax,
                             input int pstep, input int s1lo, input int s1hi,
                             input int s2lo, input int s2hi);
        write_limit(REG_CLOCK, clock);
        write_limit(REG_PMIN, pmin);
        write_limit(REG_PMAX, pmax);
        write_limit(REG_PSTEP, pstep);
        write_limit(REG_S1MIN, s1lo);
        write_limit(REG_S1MAX, s1hi);
        write_limit(REG_S2MIN, s2lo);
        write_limit(REG_S2MAX, s2hi);
    endtask

    // Mostly well-formed requests aimed at a useful quanta count; some noise.
    function automatic request_t random_request();
        request_t    rq;
        int unsigned pspan, div, rate;
        if ($urandom_range(0, 99) < 15)
        begin
            rq.rate = 24'($urandom_range(0, 16000000));
            rq.point = 11'($urandom_range(0, 2047));
            rq.from2 = 1'($urandom_range(0, 1));
            rq.jw = 8'($urandom_range(0, 255));
            rq.minq = 9'($urandom_range(0, 511));
            return rq;
        end
        pspan = (limits[REG_PMAX] > 0) ? limits[REG_PMAX] : 1;
        div = $urandom_range(4, 600) * $urandom_range(1, pspan);
        rate = limits[REG_CLOCK] / div;
        if (rate == 0) rate = 1;
        if (rate > 16000000) rate = 16000000;
        rq.rate = 24'(rate);
        rq.point = 11'($urandom_range(1, 1023));
        rq.from2 = 1'($urandom_range(0, 1));
        rq.jw = 8'($urandom_range(1, JUMP_LIMIT));
        rq.minq = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 40)) : 9'd0;
        return rq;
    endfunction

    // Default limits: request checks, an exact hit, and each boundary of the fields.
    task automatic test_request_checks;
        send_fields(500000, 875, 0, 1, 0);
        send_fields(1000000, 896, 0, 3, 0);
        send_fields(1000000, 800, 1, 0, 0);
        send_fields(1000000, 0, 0, 4, 0);
        send_fields(1000000, 1024, 0, 4, 0);
        send_fields(1000000, 2047, 1, 4, 0);
        send_fields(1000000, 1023, 0, 4, 0);
        send_fields(1000000, 1, 1, 0, 0);
        send_fields(1000000, 700, 0, 0, 0);
        send_fields(1000000, 700, 0, 128, 0);
        send_fields(1000000, 700, 0, 129, 0);
        send_fields(1000000, 700, 0, 255, 0);
        send_fields(0, 700, 0, 5, 0);
        send_fields(16000000, 700, 1, 5, 0);
        send_fields(1000000, 700, 0, 5, 511);
        send_fields(250000, 700, 1, 5, 10);
        drain();
    endtask

    // Every prescaler gives too many quanta: the full search ends with no solution.
    task automatic test_full_search;
        send_fields(1, 512, 1, 2, 0);
        drain();
    endtask

    // Broken limit settings, then the largest limits.
    task automatic test_limit_checks;
        write_all(80000000, 8, 4, 1, 2, 256, 2, 128);
        send_fields(1000000, 700, 0, 2, 0);
        drain();
        write_limit(REG_PMAX, 16);
        write_limit(REG_PSTEP, 0);
        send_fields(1000000, 700, 0, 2, 0);
        drain();
        write_all(80000000, 0, 16, 1, 2, 256, 2, 128);
        send_fields(1000000, 700, 0, 2, 0);
        drain();
        write_all(80000000, 1, 16, 4, 2, 256, 2, 128);
        send_fields(1000000, 700, 0, 2, 0);
        drain();
        write_all(80000000, 1, 16, 3, 9, 8, 2, 128);
        send_fields(1000000, 700, 0, 2, 0);
        drain();
        write_all(80000000, 1, 16, 3, 2, 256, 9, 8);
        send_fields(1000000, 700, 0, 2, 0);
        drain();
        write_all(0, 1, 16, 3, 2, 256, 2, 128);
        send_fields(1000000, 700, 0, 2, 0);
        drain();
        // Segment two pinned at a tiny maximum makes short bits skip.
        write_all(1000000000, 1, 64, 1, 1, 256, 2, 2);
        send_fields(16000000, 100, 1, 2, 0);
        send_fields(250000000 / 64, 300, 1, 2, 0);
        drain();
        write_all(1000000000, 1024, 1024, 1024, 0, 511, 0, 255);
        send_fields(1000000, 500, 1, 2, 0);
        send_fields(100000, 10, 1, 2, 0);
        drain();
    endtask

    // Results held off for a long stretch while requests keep coming.
    task automatic test_backpressure;
        write_all(80000000, 1, 32, 1, 2, 256, 2, 128);
        hold_left = 3000;
        repeat (4) send_fields(1000000, 0, 0, 1, 0);
        repeat (3) send_fields(2000000, 800, 1, 1, 0);
        drain();
    endtask

    // Random requests under several random limit settings.
    task automatic test_random;
        int pmin, pstep, s1lo, s2lo;
        for (int phase = 0; phase < 4; phase++)
        begin
            pmin = $urandom_range(1, 8);
            pstep = $urandom_range(1, 4);
            s1lo = $urandom_range(1, 4);
            s2lo = $urandom_range(1, 4);
            write_all($urandom_range(8000000, 1000000000), pmin,
                      pmin + pstep * $urandom_range(0, 48 / pstep), pstep,
                      s1lo, $urandom_range(8, 256), s2lo, $urandom_range(4, 128));
            quiet = (phase == 1);
            repeat (16) send_request(random_request());
            quiet = 0;
            drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        bit_rate = '0;
        target_point = '0;
        jump_from_seg2 = 1'b0;
        jump_width = '0;
        min_quanta = '0;
        limits = '{80000000, 1, 1024, 1, 2, 256, 2, 128};
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_request_checks();
        test_full_search();
        test_limit_checks();
        test_backpressure();
        test_random();

        wait (pending_timings.size() == 0);
        repeat (200) @(negedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: can_bit_timing_search.f
+incdir+design
design/cbts_pkg.sv
design/cbts_divider.sv
design/cbts_datapath.sv
design/cbts_ctrl.sv
design/can_bit_timing_search.sv
design/cbts_checker.sv
tb/tb_can_bit_timing_search.sv
